// File: sv/tpjp_pkg.sv
package tpjp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int HANDLE_BITS = 16;
  localparam int PTR_BITS    = $clog2(STACK_DEPTH);
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
  localparam int CAP_BITS    = 7;
  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(4);

  typedef enum logic [0:0] {
    REG_BACKGROUND_CAP = 1'b0
  } reg_e;

  typedef enum logic [1:0] {
    OP_PUSH_FG = 2'd0,
    OP_PUSH_BG = 2'd1,
    OP_REQUEST = 2'd2,
    OP_FINISH  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic finish_read;
  } cmd_t;

  typedef struct packed {
    logic need_read;
  } sts_t;

endpackage

// File: sv/tpjp_ctrl.sv
module tpjp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tpjp_pkg::sts_t   sts_i,
  output tpjp_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.need_read) begin
          state_d = S_READ;
        end else begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.finish_read = 1'b1;
        out_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_out_free_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q) else $error("result pending during work");

  a_read_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> $past(state_q == S_EXEC)) else $error("read without request");
`endif

endmodule

// File: sv/tpjp_dp.sv
module tpjp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tpjp_pkg::cmd_t                      cmd_i,
  output tpjp_pkg::sts_t                      sts_o,
  input  logic [1:0]                          opcode_i,
  input  logic [tpjp_pkg::HANDLE_BITS-1:0]    job_handle_i,
  input  logic                                cap_we_i,
  input  logic [tpjp_pkg::CAP_BITS-1:0]       cap_wdata_i,
  output logic [tpjp_pkg::CAP_BITS-1:0]       cap_o,
  output logic [1:0]                          status_o,
  output logic                                granted_o,
  output logic [tpjp_pkg::HANDLE_BITS-1:0]    job_handle_out_o,
  output logic                                was_background_o
);

  localparam logic [tpjp_pkg::CNT_BITS-1:0] FULL_CNT =
    tpjp_pkg::CNT_BITS'(tpjp_pkg::STACK_DEPTH);

  logic [tpjp_pkg::HANDLE_BITS-1:0] fg_mem [tpjp_pkg::STACK_DEPTH];
  logic [tpjp_pkg::HANDLE_BITS-1:0] bg_mem [tpjp_pkg::STACK_DEPTH];

  tpjp_pkg::op_e                    op_q;
  logic [tpjp_pkg::HANDLE_BITS-1:0] handle_q;
  logic [tpjp_pkg::CNT_BITS-1:0]    fg_cnt_q, fg_cnt_d, bg_cnt_q, bg_cnt_d;
  logic [tpjp_pkg::CAP_BITS-1:0]    running_q, running_d, cap_q;
  logic [tpjp_pkg::HANDLE_BITS-1:0] fg_rd_q, bg_rd_q;
  logic                             src_bg_q;

  logic [1:0]                       status_q, status_d;
  logic                             granted_q, granted_d, wasbg_q, wasbg_d;
  logic [tpjp_pkg::HANDLE_BITS-1:0] hout_q, hout_d;
  logic                             load_res;

  logic                             fg_full, bg_full, bg_ok, fg_ok;
  logic                             fg_push, bg_push, bg_pop, fg_pop;
  logic [tpjp_pkg::CNT_BITS-1:0]    fg_dec, bg_dec;

  assign fg_full = (fg_cnt_q == FULL_CNT);
  assign bg_full = (bg_cnt_q == FULL_CNT);
  assign bg_ok   = (bg_cnt_q != '0) && (running_q < cap_q);
  assign fg_ok   = (fg_cnt_q != '0);
  assign fg_dec  = fg_cnt_q - tpjp_pkg::CNT_BITS'(1);
  assign bg_dec  = bg_cnt_q - tpjp_pkg::CNT_BITS'(1);

  assign fg_push = cmd_i.exec && (op_q == tpjp_pkg::OP_PUSH_FG) && !fg_full;
  assign bg_push = cmd_i.exec && (op_q == tpjp_pkg::OP_PUSH_BG) && !bg_full;
  assign bg_pop  = cmd_i.exec && (op_q == tpjp_pkg::OP_REQUEST) && bg_ok;
  assign fg_pop  = cmd_i.exec && (op_q == tpjp_pkg::OP_REQUEST) && !bg_ok && fg_ok;

  assign sts_o.need_read = (op_q == tpjp_pkg::OP_REQUEST) && (bg_ok || fg_ok);

  always_comb begin
    fg_cnt_d  = fg_cnt_q;
    bg_cnt_d  = bg_cnt_q;
    running_d = running_q;
    status_d  = tpjp_pkg::STAT_OK;
    granted_d = 1'b0;
    wasbg_d   = 1'b0;
    hout_d    = '0;
    load_res  = 1'b0;
    if (cmd_i.exec) begin
      load_res = !sts_o.need_read;
      case (op_q)
        tpjp_pkg::OP_PUSH_FG: begin
          if (fg_full) begin
            status_d = tpjp_pkg::STAT_FULL;
          end else begin
            fg_cnt_d = fg_cnt_q + tpjp_pkg::CNT_BITS'(1);
          end
        end
        tpjp_pkg::OP_PUSH_BG: begin
          if (bg_full) begin
            status_d = tpjp_pkg::STAT_FULL;
          end else begin
            bg_cnt_d = bg_cnt_q + tpjp_pkg::CNT_BITS'(1);
          end
        end
        tpjp_pkg::OP_REQUEST: begin
          if (bg_ok) begin
            bg_cnt_d  = bg_dec;
            running_d = running_q + tpjp_pkg::CAP_BITS'(1);
          end else if (fg_ok) begin
            fg_cnt_d = fg_dec;
          end else begin
            status_d = tpjp_pkg::STAT_NONE;
          end
        end
        tpjp_pkg::OP_FINISH: begin
          if (running_q != '0) begin
            running_d = running_q - tpjp_pkg::CAP_BITS'(1);
          end
        end
        default: begin
          status_d = tpjp_pkg::STAT_OK;
        end
      endcase
    end else if (cmd_i.finish_read) begin
      load_res  = 1'b1;
      granted_d = 1'b1;
      wasbg_d   = src_bg_q;
      hout_d    = src_bg_q ? bg_rd_q : fg_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_cnt_q  <= '0;
      bg_cnt_q  <= '0;
      running_q <= '0;
      cap_q     <= tpjp_pkg::CAP_RESET;
    end else begin
      fg_cnt_q  <= fg_cnt_d;
      bg_cnt_q  <= bg_cnt_d;
      running_q <= running_d;
      if (cap_we_i) begin
        cap_q <= cap_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= tpjp_pkg::op_e'(opcode_i);
      handle_q <= job_handle_i;
    end
    if (fg_push) begin
      fg_mem[fg_cnt_q[tpjp_pkg::PTR_BITS-1:0]] <= handle_q;
    end
    if (bg_push) begin
      bg_mem[bg_cnt_q[tpjp_pkg::PTR_BITS-1:0]] <= handle_q;
    end
    if (fg_pop) begin
      fg_rd_q <= fg_mem[fg_dec[tpjp_pkg::PTR_BITS-1:0]];
    end
    if (bg_pop) begin
      bg_rd_q <= bg_mem[bg_dec[tpjp_pkg::PTR_BITS-1:0]];
    end
    if (cmd_i.exec) begin
      src_bg_q <= bg_ok;
    end
    if (load_res) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      wasbg_q   <= wasbg_d;
      hout_q    <= hout_d;
    end
  end

  assign cap_o            = cap_q;
  assign status_o         = status_q;
  assign granted_o        = granted_q;
  assign job_handle_out_o = hout_q;
  assign was_background_o = wasbg_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fg_cnt_q <= FULL_CNT) && (bg_cnt_q <= FULL_CNT)) else $error("stack count overflow");

  a_state_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(fg_cnt_q) && $stable(bg_cnt_q) && $stable(running_q))
    else $error("state changed outside execution");

  a_bg_grant_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bg_pop |-> (running_q < cap_q) && (bg_cnt_q != '0)) else $error("background over cap");
`endif

endmodule

// File: sv/two_pool_job_picker_with_background_cap.sv
// Job picker with a foreground and a background LIFO stack of job handles.
// Input channel (in_valid_i/in_ready_o) carries opcode_i and job_handle_i:
// push foreground, push background, request a job, or background finished.
// Output channel (out_valid_o/out_ready_i) returns one result per transaction:
// status_o, granted_o, job_handle_out_o and was_background_o.
// A request pops the background stack when it is non-empty and fewer than
// background_cap background jobs run; else it pops the foreground stack, if non-empty.
// background_cap sits at APB address 0; the user must write it only while
// idle, and the block itself does not enforce this. The result is registered
// after the execute state, or after the read-back state for a request that
// hands out a job, because the stack memory read is registered. A new
// transaction is accepted only in the idle state, after those states.
// A new transaction is accepted while the previous result is taken in the
// same cycle; while the receiver stalls the result holds and input stalls.
// Reset empties both stacks, clears the running count and sets the cap to 4.
module two_pool_job_picker_with_background_cap (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             opcode_i,
  input  logic [tpjp_pkg::HANDLE_BITS-1:0]       job_handle_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [1:0]                             status_o,
  output logic                                   granted_o,
  output logic [tpjp_pkg::HANDLE_BITS-1:0]       job_handle_out_o,
  output logic                                   was_background_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tpjp_pkg::PADDR_BITS-1:0]        paddr,
  input  logic [tpjp_pkg::PDATA_BITS-1:0]        pwdata,
  output logic [tpjp_pkg::PDATA_BITS-1:0]        prdata,
  output logic                                   pready
);

  tpjp_pkg::cmd_t                cmd;
  tpjp_pkg::sts_t                sts;
  logic                          reg_sel;
  logic                          cap_we;
  logic [tpjp_pkg::CAP_BITS-1:0] cap;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[tpjp_pkg::PADDR_BITS-1:2] == tpjp_pkg::REG_BACKGROUND_CAP);
  assign cap_we  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? tpjp_pkg::PDATA_BITS'(cap) : '0;

  tpjp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpjp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .job_handle_i     (job_handle_i),
    .cap_we_i         (cap_we),
    .cap_wdata_i      (pwdata[tpjp_pkg::CAP_BITS-1:0]),
    .cap_o            (cap),
    .status_o         (status_o),
    .granted_o        (granted_o),
    .job_handle_out_o (job_handle_out_o),
    .was_background_o (was_background_o)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [tpjp_pkg::PADDR_BITS-1:0] CAP_ADDR =
    {tpjp_pkg::REG_BACKGROUND_CAP, 2'b00};
  localparam logic [tpjp_pkg::PADDR_BITS-1:0] SPARE_ADDR = tpjp_pkg::PADDR_BITS'(4);

  typedef struct {
    tpjp_pkg::op_e                    op;
    logic [tpjp_pkg::HANDLE_BITS-1:0] handle;
  } job_t;

  typedef struct {
    tpjp_pkg::status_e                status;
    logic                             granted;
    logic [tpjp_pkg::HANDLE_BITS-1:0] handle;
    logic                             from_bg;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             in_valid = 1'b0;
  tpjp_pkg::op_e                    cur_op = tpjp_pkg::OP_PUSH_FG;
  logic [tpjp_pkg::HANDLE_BITS-1:0] cur_handle = '0;
  logic                             out_ready = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [tpjp_pkg::PADDR_BITS-1:0]  paddr = '0;
  logic [tpjp_pkg::PDATA_BITS-1:0]  pwdata = '0;

  logic                             in_ready;
  logic                             out_valid;
  logic [1:0]                       status_o;
  logic                             granted_o;
  logic [tpjp_pkg::HANDLE_BITS-1:0] handle_o;
  logic                             from_bg_o;
  logic [tpjp_pkg::PDATA_BITS-1:0]  prdata;
  logic                             pready;

  job_t  pending_jobs[$];
  pick_t expected_picks[$];

  logic [tpjp_pkg::HANDLE_BITS-1:0] fg_stack[tpjp_pkg::STACK_DEPTH];
  logic [tpjp_pkg::HANDLE_BITS-1:0] bg_stack[tpjp_pkg::STACK_DEPTH];
  int fg_depth = 0;
  int bg_depth = 0;
  int bg_running = 0;
  int bg_cap = tpjp_pkg::CAP_RESET;

  int queued_n = 0;
  int picked_n = 0;
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit idle_en = 1'b1;
  int n_fg = 0, n_bg = 0, n_none = 0, n_full = 0, n_finish = 0, n_caps = 0;

  two_pool_job_picker_with_background_cap dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (cur_op),
    .job_handle_i     (cur_handle),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status_o),
    .granted_o        (granted_o),
    .job_handle_out_o (handle_o),
    .was_background_o (from_bg_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic pick_t predict_pick(tpjp_pkg::op_e op,
                                         logic [tpjp_pkg::HANDLE_BITS-1:0] handle);
    pick_t r;
    r.status  = tpjp_pkg::STAT_OK;
    r.granted = 1'b0;
    r.handle  = '0;
    r.from_bg = 1'b0;
    case (op)
      tpjp_pkg::OP_PUSH_FG: begin
        if (fg_depth >= tpjp_pkg::STACK_DEPTH) begin
          r.status = tpjp_pkg::STAT_FULL;
          n_full++;
        end else begin
          fg_stack[fg_depth] = handle;
          fg_depth++;
        end
      end
      tpjp_pkg::OP_PUSH_BG: begin
        if (bg_depth >= tpjp_pkg::STACK_DEPTH) begin
          r.status = tpjp_pkg::STAT_FULL;
          n_full++;
        end else begin
          bg_stack[bg_depth] = handle;
          bg_depth++;
        end
      end
      tpjp_pkg::OP_REQUEST: begin
        if (bg_depth > 0 && bg_running < bg_cap) begin
          bg_depth--;
          r.handle  = bg_stack[bg_depth];
          r.granted = 1'b1;
          r.from_bg = 1'b1;
          bg_running++;
          n_bg++;
        end else if (fg_depth > 0) begin
          fg_depth--;
          r.handle  = fg_stack[fg_depth];
          r.granted = 1'b1;
          n_fg++;
        end else begin
          r.status = tpjp_pkg::STAT_NONE;
          n_none++;
        end
      end
      default: begin
        if (bg_running > 0) bg_running--;
        n_finish++;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    job_t nxt;
    bit   launch;
    bit   free;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      launch = 1'b0;
      free = !in_valid || in_ready;
      if (in_valid && in_ready) expected_picks.push_back(predict_pick(cur_op, cur_handle));
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_jobs.size() > 0) begin
          if (idle_en && $urandom_range(0, 7) == 0) gap_left = $urandom_range(0, 10);
          else launch = 1'b1;
        end
      end
      if (launch) begin
        nxt = pending_jobs.pop_front();
        cur_op     <= nxt.op;
        cur_handle <= nxt.handle;
        in_valid   <= 1'b1;
      end else if (free) begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    pick_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d handle %0d",
                   $time, status_o, handle_o);
          errors++;
        end else begin
          want = expected_picks.pop_front();
          check_field("status", want.status, status_o);
          check_field("granted", want.granted, granted_o);
          check_field("job_handle_out", want.handle, handle_o);
          check_field("was_background", want.from_bg, from_bg_o);
          picked_n++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_job(tpjp_pkg::op_e kind, logic [tpjp_pkg::HANDLE_BITS-1:0] value);
    job_t j;
    j.op = kind;
    j.handle = value;
    pending_jobs.push_back(j);
    queued_n++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (picked_n != queued_n);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tpjp_pkg::PADDR_BITS-1:0] addr,
                           logic [tpjp_pkg::PDATA_BITS-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CAP_ADDR) bg_cap = int'(data[tpjp_pkg::CAP_BITS-1:0]);
    n_caps++;
  endtask

  task automatic add_random_jobs(int count);
    int run_left;
    int mode;
    int roll;
    int pick;
    logic [tpjp_pkg::HANDLE_BITS-1:0] h;
    run_left = 0;
    mode = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        mode = $urandom_range(0, 3);
        run_left = $urandom_range(10, 45);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 15);
      h = (pick == 0) ? '0 : (pick == 1) ? '1 :
          tpjp_pkg::HANDLE_BITS'($urandom_range(0, 65535));
      case (mode)
        0: begin
          if (roll < 80) add_job(tpjp_pkg::OP_PUSH_FG, h);
          else if (roll < 92) add_job(tpjp_pkg::OP_REQUEST, h);
          else add_job(tpjp_pkg::OP_FINISH, h);
        end
        1: begin
          if (roll < 80) add_job(tpjp_pkg::OP_PUSH_BG, h);
          else if (roll < 92) add_job(tpjp_pkg::OP_REQUEST, h);
          else add_job(tpjp_pkg::OP_FINISH, h);
        end
        2: begin
          if (roll < 10) add_job(tpjp_pkg::OP_PUSH_FG, h);
          else if (roll < 20) add_job(tpjp_pkg::OP_PUSH_BG, h);
          else if (roll < 80) add_job(tpjp_pkg::OP_REQUEST, h);
          else add_job(tpjp_pkg::OP_FINISH, h);
        end
        default: begin
          add_job(tpjp_pkg::op_e'($urandom_range(0, 3)), h);
        end
      endcase
    end
    wait_idle();
  endtask

  initial begin
    @(posedge clk_i);
    @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_job(tpjp_pkg::OP_REQUEST, 16'h1234);
    add_job(tpjp_pkg::OP_FINISH, 16'hFFFF);
    add_job(tpjp_pkg::OP_PUSH_FG, 16'h0000);
    add_job(tpjp_pkg::OP_PUSH_FG, 16'hFFFF);
    add_job(tpjp_pkg::OP_PUSH_BG, 16'h8001);
    add_job(tpjp_pkg::OP_PUSH_BG, 16'h7FFE);
    repeat (5) add_job(tpjp_pkg::OP_REQUEST, 16'h0000);
    repeat (2) add_job(tpjp_pkg::OP_FINISH, 16'h0000);
    for (int i = 1; i <= 5; i++) add_job(tpjp_pkg::OP_PUSH_BG, tpjp_pkg::HANDLE_BITS'(i));
    repeat (5) add_job(tpjp_pkg::OP_REQUEST, 16'hFFFF);
    add_job(tpjp_pkg::OP_PUSH_FG, 16'hABCD);
    add_job(tpjp_pkg::OP_REQUEST, 16'h0000);
    wait_idle();

    write_reg(CAP_ADDR, 32'd1);
    add_job(tpjp_pkg::OP_REQUEST, 16'h0000);
    repeat (3) add_job(tpjp_pkg::OP_FINISH, 16'h0000);
    add_job(tpjp_pkg::OP_REQUEST, 16'h0000);
    add_job(tpjp_pkg::OP_FINISH, 16'h0000);
    add_job(tpjp_pkg::OP_REQUEST, 16'h0000);
    wait_idle();

    write_reg(SPARE_ADDR, 32'd0);
    add_random_jobs(104);
    write_reg(CAP_ADDR, 32'd0);
    add_random_jobs(104);
    write_reg(CAP_ADDR, 32'd64);
    add_random_jobs(104);
    write_reg(CAP_ADDR, 32'($urandom_range(2, 63)));
    add_random_jobs(104);
    idle_en = 1'b0;
    write_reg(CAP_ADDR, 32'd3);
    add_random_jobs(104);

    repeat (10) @(posedge clk_i);
    if (expected_picks.size() != 0) begin
      $display("%0t: %0d results missing at end of run", $time, expected_picks.size());
      errors++;
    end
    $display("Checked %0d transactions over %0d register writes: %0d foreground grants,",
             picked_n, n_caps, n_fg);
    $display("  %0d background grants, %0d empty requests, %0d full pushes, %0d finishes",
             n_bg, n_none, n_full, n_finish);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tpjp_pkg.sv
sv/tpjp_ctrl.sv
sv/tpjp_dp.sv
sv/two_pool_job_picker_with_background_cap.sv
tb/sv/tb_top.sv
